// ===== rtl/tvdma_pkg.sv =====
package tvdma_pkg;

    // one input beat
    typedef struct packed {
        logic        func;
        logic [15:0] pixel_value;
    } tvdma_in_t;

    // one result beat
    typedef struct packed {
        logic [9:0]         out_row;
        logic [9:0]         out_col;
        logic signed [39:0] diag_coef;
        logic signed [39:0] up_coef;
        logic signed [39:0] left_coef;
        logic signed [39:0] right_coef;
        logic signed [39:0] down_coef;
        logic               image_done;
    } tvdma_out_t;

    // configuration write as seen inside the block
    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [15:0] data;
    } tvdma_cfg_t;

    // register indexes
    localparam logic [1:0] CFG_ALPHA  = 2'd0;
    localparam logic [1:0] CFG_BETA   = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    // input function codes
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // register reset values
    localparam logic [15:0] ALPHA_RESET  = 16'd1280;
    localparam logic [15:0] BETA_RESET   = 16'd7;
    localparam logic [10:0] SIZE_RESET   = 11'd256;

    // iteration counts: 2^48 / s gives 49 quotient bits, root of 50 bits takes 25 steps
    localparam int DIV_STEPS  = 49;
    localparam int SQRT_STEPS = 25;

    // fixed point constants
    localparam logic [23:0] DIFF_MAX = 24'hFF_FFFF;
    localparam logic [39:0] ONE_Q16  = 40'd65536;

    // datapath commands
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_WSAMP,
        OP_RD0,
        OP_RD1,
        OP_RD2,
        OP_SQX,
        OP_SQY,
        OP_DIV,
        OP_SQRT,
        OP_WRITE,
        OP_SUM,
        OP_MUL_UP,
        OP_MUL_LEFT,
        OP_MUL_SELF,
        OP_MUL_SUM,
        OP_EMIT
    } tvdma_op_t;

    // neighbour and item flags of the pixel in work
    typedef struct packed {
        logic has_up;
        logic has_left;
        logic has_right;
        logic has_down;
        logic flush;
        logic done;
    } tvdma_flags_t;

    typedef struct packed {
        tvdma_op_t    op;
        tvdma_flags_t flags;
    } tvdma_cmd_t;

endpackage

// ===== rtl/tvdma_ram.sv =====
module tvdma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1025
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tvdma_datapath.sv =====
module tvdma_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tvdma_pkg::tvdma_cfg_t                cfg,
    input  tvdma_pkg::tvdma_cmd_t                cmd,
    input  logic [15:0]                          pixel_in,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]      pos_row,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       pos_col,
    output tvdma_pkg::tvdma_out_t                result
);
    import tvdma_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [15:0] alpha_reg;
    logic [15:0] beta_reg;
    logic [15:0] pix_reg;
    logic [15:0] above_reg;
    logic [23:0] dup_reg;
    logic [23:0] dleft_reg;
    logic [15:0] ax_reg;
    logic [15:0] ay_reg;
    logic [32:0] s_reg;
    logic [32:0] rem_reg;
    logic [48:0] num_reg;
    logic [49:0] q_reg;
    logic [26:0] srem_reg;
    logic [24:0] root_reg;
    logic [23:0] d_reg;
    logic [25:0] sum_reg;
    logic [31:0] up_mag_reg;
    logic [31:0] left_mag_reg;
    logic [31:0] self_mag_reg;
    logic [33:0] diag_mag_reg;
    tvdma_out_t  out_reg;

    logic [AW-1:0] samp_raddr;
    logic [AW-1:0] diff_raddr;
    logic          samp_we;
    logic          diff_we;
    logic [15:0]   samp_rdata;
    logic [23:0]   diff_rdata;
    logic [23:0]   d_sat;

    logic [15:0]   mul_a;
    logic [25:0]   mul_b;
    logic [41:0]   prod;

    logic [33:0]   rem2;
    logic          q_bit;
    logic [28:0]   srem2;
    logic [28:0]   trial;
    logic          r_bit;

    logic [15:0]   dx_mag;
    logic [15:0]   dy_mag;
    logic [HW+9:0] row_ext;
    logic [AW+9:0] col_ext;

    // line buffers
    assign samp_raddr = (cmd.op == OP_RD0) ? pos_col : pos_col + AW'(1);
    assign diff_raddr = (cmd.op == OP_RD0) ? pos_col : pos_col - AW'(1);
    assign samp_we    = (cmd.op == OP_WSAMP) || ((cmd.op == OP_WRITE) && !cmd.flags.flush);
    assign diff_we    = (cmd.op == OP_WRITE);

    tvdma_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH + 1)) u_sample_line (
        .aclk  (aclk),
        .we    (samp_we),
        .waddr (pos_col),
        .wdata (pix_reg),
        .raddr (samp_raddr),
        .rdata (samp_rdata)
    );

    tvdma_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH + 1)) u_diff_line (
        .aclk  (aclk),
        .we    (diff_we),
        .waddr (pos_col),
        .wdata (d_sat),
        .raddr (diff_raddr),
        .rdata (diff_rdata)
    );

    // forward difference magnitudes
    assign dx_mag = !cmd.flags.has_right ? 16'd0 :
                    (samp_rdata >= above_reg) ? samp_rdata - above_reg : above_reg - samp_rdata;
    assign dy_mag = cmd.flags.flush ? 16'd0 :
                    (pix_reg >= above_reg) ? pix_reg - above_reg : above_reg - pix_reg;

    // shared multiplier
    always_comb begin
        mul_a = alpha_reg;
        mul_b = '0;
        case (cmd.op)
            OP_SQX: begin
                mul_a = ax_reg;
                mul_b = {10'd0, ax_reg};
            end
            OP_SQY: begin
                mul_a = ay_reg;
                mul_b = {10'd0, ay_reg};
            end
            OP_MUL_UP:   mul_b = {2'd0, dup_reg};
            OP_MUL_LEFT: mul_b = {2'd0, dleft_reg};
            OP_MUL_SELF: mul_b = {2'd0, d_reg};
            OP_MUL_SUM:  mul_b = sum_reg;
            default:     mul_b = '0;
        endcase
    end

    assign prod = {26'd0, mul_a} * {16'd0, mul_b};

    // restoring divide step for 2^48 / s
    assign rem2  = {rem_reg, num_reg[48]};
    assign q_bit = (rem2 >= {1'b0, s_reg});

    // digit-by-digit square root step
    assign srem2 = {srem_reg, q_reg[49:48]};
    assign trial = {2'd0, root_reg, 2'b01};
    assign r_bit = (srem2 >= trial);

    assign d_sat = root_reg[24] ? DIFF_MAX : root_reg[23:0];

    assign row_ext = {10'd0, pos_row};
    assign col_ext = {10'd0, pos_col};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RESET;
            beta_reg  <= BETA_RESET;
        end else if (cfg.we) begin
            if (cfg.index == CFG_ALPHA) begin
                alpha_reg <= cfg.data;
            end
            if (cfg.index == CFG_BETA) begin
                beta_reg <= cfg.data;
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                pix_reg <= pixel_in;
            end
            OP_RD1: begin
                above_reg <= samp_rdata;
                dup_reg   <= diff_rdata;
            end
            OP_RD2: begin
                dleft_reg <= diff_rdata;
                ax_reg    <= dx_mag;
                ay_reg    <= dy_mag;
            end
            OP_SQX: begin
                s_reg <= {1'b0, prod[31:0]} + {17'd0, beta_reg};
            end
            OP_SQY: begin
                s_reg    <= s_reg + {1'b0, prod[31:0]};
                rem_reg  <= '0;
                num_reg  <= {1'b1, 48'd0};
                q_reg    <= '0;
                srem_reg <= '0;
                root_reg <= '0;
            end
            OP_DIV: begin
                rem_reg <= q_bit ? 33'(rem2 - {1'b0, s_reg}) : rem2[32:0];
                num_reg <= {num_reg[47:0], 1'b0};
                q_reg   <= {q_reg[48:0], q_bit};
            end
            OP_SQRT: begin
                srem_reg <= r_bit ? 27'(srem2 - trial) : srem2[26:0];
                root_reg <= {root_reg[23:0], r_bit};
                q_reg    <= {q_reg[47:0], 2'b00};
            end
            OP_WRITE: begin
                d_reg <= d_sat;
            end
            OP_SUM: begin
                sum_reg <= (cmd.flags.has_up    ? {2'd0, dup_reg}   : 26'd0)
                         + (cmd.flags.has_left  ? {2'd0, dleft_reg} : 26'd0)
                         + (cmd.flags.has_right ? {2'd0, d_reg}     : 26'd0)
                         + (cmd.flags.has_down  ? {2'd0, d_reg}     : 26'd0);
            end
            OP_MUL_UP:   up_mag_reg   <= prod[39:8];
            OP_MUL_LEFT: left_mag_reg <= prod[39:8];
            OP_MUL_SELF: self_mag_reg <= prod[39:8];
            OP_MUL_SUM:  diag_mag_reg <= prod[41:8];
            OP_EMIT: begin
                out_reg.out_row    <= row_ext[9:0];
                out_reg.out_col    <= col_ext[9:0];
                out_reg.diag_coef  <= ONE_Q16 + {6'd0, diag_mag_reg};
                out_reg.up_coef    <= cmd.flags.has_up ? 40'd0 - {8'd0, up_mag_reg} : 40'd0;
                out_reg.left_coef  <= cmd.flags.has_left ? 40'd0 - {8'd0, left_mag_reg} : 40'd0;
                out_reg.right_coef <= cmd.flags.has_right ? 40'd0 - {8'd0, self_mag_reg} : 40'd0;
                out_reg.down_coef  <= cmd.flags.has_down ? 40'd0 - {8'd0, self_mag_reg} : 40'd0;
                out_reg.image_done <= cmd.flags.done;
            end
            default: begin
            end
        endcase
    end

    assign result = out_reg;

endmodule

// ===== rtl/tvdma_ctrl.sv =====
module tvdma_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tvdma_pkg::tvdma_cfg_t            cfg,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_func,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tvdma_pkg::tvdma_cmd_t            cmd,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]  pos_row,
    output logic [$clog2(MAX_WIDTH+1)-1:0]   pos_col
);
    import tvdma_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WSAMP,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_SQX,
        ST_SQY,
        ST_DIV,
        ST_SQRT,
        ST_WRITE,
        ST_SUM,
        ST_MUL_UP,
        ST_MUL_LEFT,
        ST_MUL_SELF,
        ST_MUL_SUM,
        ST_EMIT,
        ST_OUT
    } state_t;

    state_t        state_reg;
    logic [5:0]    step_reg;
    logic [CW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [CW-1:0] in_col_reg;
    logic [HW-1:0] in_row_reg;
    logic [HW-1:0] pos_row_reg;
    logic [CW-1:0] pos_col_reg;
    tvdma_flags_t  flags_reg;

    logic          accept;
    logic [CW:0]   col_inc;
    logic          col_last;

    function automatic logic [CW-1:0] clamp_w(input logic [10:0] v);
        int vi;
        vi = int'(v);
        if (vi < 1) vi = 1;
        if (vi > MAX_WIDTH) vi = MAX_WIDTH;
        return CW'(vi);
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [10:0] v);
        int vi;
        vi = int'(v);
        if (vi < 1) vi = 1;
        if (vi > MAX_HEIGHT) vi = MAX_HEIGHT;
        return HW'(vi);
    endfunction

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign col_inc  = {1'b0, in_col_reg} + (CW+1)'(1);
    assign col_last = (col_inc == {1'b0, w_reg});

    // command decode
    always_comb begin
        cmd.flags = flags_reg;
        case (state_reg)
            ST_IDLE:     cmd.op = accept ? OP_LOAD : OP_IDLE;
            ST_WSAMP:    cmd.op = OP_WSAMP;
            ST_RD0:      cmd.op = OP_RD0;
            ST_RD1:      cmd.op = OP_RD1;
            ST_RD2:      cmd.op = OP_RD2;
            ST_SQX:      cmd.op = OP_SQX;
            ST_SQY:      cmd.op = OP_SQY;
            ST_DIV:      cmd.op = OP_DIV;
            ST_SQRT:     cmd.op = OP_SQRT;
            ST_WRITE:    cmd.op = OP_WRITE;
            ST_SUM:      cmd.op = OP_SUM;
            ST_MUL_UP:   cmd.op = OP_MUL_UP;
            ST_MUL_LEFT: cmd.op = OP_MUL_LEFT;
            ST_MUL_SELF: cmd.op = OP_MUL_SELF;
            ST_MUL_SUM:  cmd.op = OP_MUL_SUM;
            ST_EMIT:     cmd.op = OP_EMIT;
            default:     cmd.op = OP_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign pos_row = pos_row_reg;
    assign pos_col = pos_col_reg;

    // sequencer, raster counters and image size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            w_reg       <= clamp_w(SIZE_RESET);
            h_reg       <= clamp_h(SIZE_RESET);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            pos_row_reg <= '0;
            pos_col_reg <= '0;
            flags_reg   <= '0;
        end else begin
            // size writes restart the image
            if (cfg.we && (cfg.index == CFG_WIDTH)) begin
                w_reg      <= clamp_w(cfg.data[10:0]);
                in_col_reg <= '0;
                in_row_reg <= '0;
            end
            if (cfg.we && (cfg.index == CFG_HEIGHT)) begin
                h_reg      <= clamp_h(cfg.data[10:0]);
                in_col_reg <= '0;
                in_row_reg <= '0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        pos_col_reg <= in_col_reg;
                        if (s_func == FUNC_PIXEL) begin
                            if (in_row_reg < h_reg) begin
                                pos_row_reg        <= in_row_reg - HW'(1);
                                flags_reg.has_up    <= (in_row_reg > HW'(1));
                                flags_reg.has_left  <= (in_col_reg != '0);
                                flags_reg.has_right <= !col_last;
                                flags_reg.has_down  <= 1'b1;
                                flags_reg.flush     <= 1'b0;
                                flags_reg.done      <= 1'b0;
                                if (col_last) begin
                                    in_col_reg <= '0;
                                    in_row_reg <= in_row_reg + HW'(1);
                                end else begin
                                    in_col_reg <= col_inc[CW-1:0];
                                end
                                state_reg <= (in_row_reg == '0) ? ST_WSAMP : ST_RD0;
                            end
                        end else begin
                            if (in_row_reg >= h_reg) begin
                                pos_row_reg        <= h_reg - HW'(1);
                                flags_reg.has_up    <= (h_reg > HW'(1));
                                flags_reg.has_left  <= (in_col_reg != '0);
                                flags_reg.has_right <= !col_last;
                                flags_reg.has_down  <= 1'b0;
                                flags_reg.flush     <= 1'b1;
                                flags_reg.done      <= col_last;
                                if (col_last) begin
                                    in_col_reg <= '0;
                                    in_row_reg <= '0;
                                end else begin
                                    in_col_reg <= col_inc[CW-1:0];
                                end
                                state_reg <= ST_RD0;
                            end
                        end
                    end
                end
                ST_WSAMP:    state_reg <= ST_IDLE;
                ST_RD0:      state_reg <= ST_RD1;
                ST_RD1:      state_reg <= ST_RD2;
                ST_RD2:      state_reg <= ST_SQX;
                ST_SQX:      state_reg <= ST_SQY;
                ST_SQY: begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (step_reg == 6'(DIV_STEPS - 1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_SQRT;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_SQRT: begin
                    if (step_reg == 6'(SQRT_STEPS - 1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_WRITE;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_WRITE:    state_reg <= ST_SUM;
                ST_SUM:      state_reg <= ST_MUL_UP;
                ST_MUL_UP:   state_reg <= ST_MUL_LEFT;
                ST_MUL_LEFT: state_reg <= ST_MUL_SELF;
                ST_MUL_SELF: state_reg <= ST_MUL_SUM;
                ST_MUL_SUM:  state_reg <= ST_EMIT;
                ST_EMIT:     state_reg <= ST_OUT;
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/tv_diffusivity_matrix_assembly.sv =====
// an emitting beat runs the read, square, divide, square root, write, sum,
// multiply and emit states; the bit-serial divider (49 steps) and square
// root (25 steps) share one sequencer; beats are taken only while idle
// a first-row pixel only writes the sample line, an ignored beat is dropped
// reset: aresetn low synchronously restores control and config registers
// and restarts the image; line buffers and arithmetic registers are not cleared
module tv_diffusivity_matrix_assembly #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tvdma_pkg::tvdma_in_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tvdma_pkg::tvdma_out_t  m_data,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data
);
    import tvdma_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    tvdma_cfg_t    cfg;
    tvdma_cmd_t    cmd;
    logic [HW-1:0] pos_row;
    logic [CW-1:0] pos_col;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // control sequencer
    tvdma_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_data.func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .pos_row (pos_row),
        .pos_col (pos_col)
    );

    // line buffers and arithmetic
    tvdma_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .pixel_in (s_data.pixel_value),
        .pos_row  (pos_row),
        .pos_col  (pos_col),
        .result   (m_data)
    );

endmodule
